// ===== design/tide_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tide_pkg;
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH,
      ST_WRAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic run;
      logic finish;
      logic wrap;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic last;
   } sts_type;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_HIGH = 2'd1;
   localparam logic [1:0] KIND_LOW  = 2'd2;

   localparam int unsigned DAY_SECONDS = 86400;
   localparam int unsigned MAX_MINUTES = 1440;

   localparam logic [3:0] CSR_AMP_PRIMARY    = 4'd0;
   localparam logic [3:0] CSR_AMP_SECONDARY  = 4'd1;
   localparam logic [3:0] CSR_RATE_PRIMARY   = 4'd2;
   localparam logic [3:0] CSR_RATE_SECONDARY = 4'd3;
   localparam logic [3:0] CSR_STEP_SECONDS   = 4'd4;
endpackage
`default_nettype wire

// ===== design/tide_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tide_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire tide_pkg::sts_type sts,
   output logic                   busy,
   output tide_pkg::cmd_type      cmd
);
   import tide_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.run  = 1'b1;
            state_in = sts.last ? ST_FINISH : ST_RUN;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.done = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== design/tide_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tide_dp #(
   parameter int unsigned SAMPLES         = 240,
   parameter int unsigned SINE_TABLE_BITS = 10
) (
   input  wire logic               clock,
   input  wire tide_pkg::cmd_type  cmd,
   output tide_pkg::sts_type       sts,
   input  wire logic [11:0]        amp_primary,
   input  wire logic [11:0]        amp_secondary,
   input  wire logic [19:0]        rate_primary,
   input  wire logic [19:0]        rate_secondary,
   input  wire logic [8:0]         step_seconds,
   input  wire logic [16:0]        time_now,
   input  wire logic signed [17:0] loc_offset,
   input  wire logic [10:0]        alert_threshold,
   output logic                    out_valid,
   output logic signed [13:0]      level_now,
   output logic [1:0]              event_kind,
   output logic signed [13:0]      event_level,
   output logic [16:0]             event_time,
   output logic [10:0]             minutes_until,
   output logic                    alert
);
   import tide_pkg::*;

   localparam int          IW        = 10;
   localparam int          CW        = IW + 1;
   localparam int          TB        = SINE_TABLE_BITS;
   localparam int          LW        = 15;
   localparam logic [26:0] DAY_RECIP = 27'd12428;
   localparam int          DAY_SHIFT = 23;
   localparam logic [38:0] MIN_RECIP = 39'd559241;
   localparam int          MIN_SHIFT = 25;

   function automatic logic [14:0] fold_z(input logic [TB-1:0] p);
      logic [13:0] r;
      begin
         r      = 14'(32'(p) << (16 - TB));
         fold_z = p[TB-2] ? 15'(15'd16384 - 15'(r)) : 15'(r);
      end
   endfunction

   function automatic logic [15:0] mul_q14(input logic [14:0] x, input logic [14:0] y);
      mul_q14 = 16'((30'(x) * 30'(y)) >> 14);
   endfunction

   logic [16:0]          now_ff;
   logic [10:0]          thr_ff;
   logic [31:0]          t_ff;
   logic [CW-1:0]        iss_ff;
   logic [IW-1:0]        idx_ff;
   logic [5:0]           vld_ff;
   logic [TB-1:0]        p_ff [2];
   logic [1:0]           q_a_ff [2];
   logic [1:0]           q_b_ff [2];
   logic [1:0]           q_c_ff [2];
   logic [14:0]          z_a_ff [2];
   logic [14:0]          z_b_ff [2];
   logic [14:0]          z_c_ff [2];
   logic [14:0]          zz_a_ff [2];
   logic [14:0]          zz_b_ff [2];
   logic [14:0]          u_b_ff [2];
   logic [14:0]          u_c_ff [2];
   logic signed [15:0]   s_ff [2];
   logic signed [LW-1:0] cur_ff, r0_ff, r1_ff, hv_ff, lv_ff;
   logic                 hf_ff, lf_ff;
   logic [IW-1:0]        hi_ff, li_ff;
   logic [18:0]          delta_ff;
   logic [1:0]           kind_ff;
   logic signed [13:0]   evl_ff;
   logic [19:0]          sum_ff;
   logic [3:0]           dayq_ff;
   logic [10:0]          mins_ff;

   logic [31:0]          ph1, ph2;
   logic signed [29:0]   v;
   logic                 issue;
   logic [18:0]          delta_c;
   logic [19:0]          sum_c;
   logic [3:0]           dayq_c;
   logic [13:0]          mins_c;

   assign ph1   = t_ff * 32'(rate_primary);
   assign ph2   = t_ff * 32'(rate_secondary);
   assign v     = $signed({1'b0, amp_primary}) * s_ff[0]
                + $signed({1'b0, amp_secondary}) * s_ff[1] + 30'sd8192;
   assign issue = (iss_ff <= CW'(SAMPLES));
   assign sts.last = vld_ff[5] && (idx_ff == IW'(SAMPLES));

   always_comb begin
      delta_c = '0;
      if (hf_ff && (!lf_ff || hi_ff < li_ff)) begin
         delta_c = 19'(hi_ff) * 19'(step_seconds);
      end else if (lf_ff) begin
         delta_c = 19'(li_ff) * 19'(step_seconds);
      end
   end

   assign sum_c  = 20'(now_ff) + 20'(delta_ff);
   assign dayq_c = 4'((27'(sum_c >> 7) * DAY_RECIP) >> DAY_SHIFT);
   assign mins_c = 14'((39'(delta_ff) * MIN_RECIP) >> MIN_SHIFT);

   always_ff @(posedge clock) begin
      out_valid <= cmd.done;
      if (cmd.load) begin
         now_ff <= time_now;
         thr_ff <= alert_threshold;
         t_ff   <= 32'($signed({1'b0, time_now})) + 32'(loc_offset);
         iss_ff <= '0;
         idx_ff <= '0;
         vld_ff <= '0;
         hf_ff  <= 1'b0;
         lf_ff  <= 1'b0;
         hi_ff  <= '0;
         li_ff  <= '0;
         hv_ff  <= '0;
         lv_ff  <= '0;
         r0_ff  <= '0;
         r1_ff  <= '0;
      end else if (cmd.run) begin
         vld_ff <= {vld_ff[4:0], issue};
         if (issue) begin
            p_ff[0] <= ph1[31 -: TB];
            p_ff[1] <= ph2[31 -: TB];
            t_ff    <= t_ff + 32'(step_seconds);
            iss_ff  <= iss_ff + CW'(1);
         end
         for (int k = 0; k < 2; k++) begin
            q_a_ff[k]  <= p_ff[k][TB-1 -: 2];
            z_a_ff[k]  <= fold_z(p_ff[k]);
            zz_a_ff[k] <= 15'(mul_q14(fold_z(p_ff[k]), fold_z(p_ff[k])));
            q_b_ff[k]  <= q_a_ff[k];
            z_b_ff[k]  <= z_a_ff[k];
            zz_b_ff[k] <= zz_a_ff[k];
            u_b_ff[k]  <= 15'(15'd10583 - 15'(mul_q14(15'd1231, zz_a_ff[k])));
            q_c_ff[k]  <= q_b_ff[k];
            z_c_ff[k]  <= z_b_ff[k];
            u_c_ff[k]  <= 15'(15'd25736 - 15'(mul_q14(u_b_ff[k], zz_b_ff[k])));
            s_ff[k]    <= q_c_ff[k][1] ? $signed(16'(-mul_q14(u_c_ff[k], z_c_ff[k])))
                                       : $signed(mul_q14(u_c_ff[k], z_c_ff[k]));
         end
         cur_ff <= LW'(v >>> 14);
         if (vld_ff[5]) begin
            if (idx_ff == '0) level_now <= 14'(cur_ff);
            if (idx_ff >= IW'(2)) begin
               if (r0_ff > r1_ff && r0_ff > cur_ff) begin
                  if (!hf_ff) begin
                     hf_ff <= 1'b1;
                     hi_ff <= idx_ff - IW'(1);
                     hv_ff <= r0_ff;
                  end
               end else if (r0_ff < r1_ff && r0_ff < cur_ff) begin
                  if (!lf_ff) begin
                     lf_ff <= 1'b1;
                     li_ff <= idx_ff - IW'(1);
                     lv_ff <= r0_ff;
                  end
               end
            end
            r1_ff  <= r0_ff;
            r0_ff  <= cur_ff;
            idx_ff <= idx_ff + IW'(1);
         end
      end
      if (cmd.finish) begin
         delta_ff <= delta_c;
         if (hf_ff && (!lf_ff || hi_ff < li_ff)) begin
            kind_ff <= KIND_HIGH;
            evl_ff  <= 14'(hv_ff);
         end else if (lf_ff) begin
            kind_ff <= KIND_LOW;
            evl_ff  <= 14'(lv_ff);
         end else begin
            kind_ff <= KIND_NONE;
            evl_ff  <= '0;
         end
      end
      if (cmd.wrap) begin
         sum_ff  <= sum_c;
         dayq_ff <= dayq_c;
         mins_ff <= (mins_c > 14'(MAX_MINUTES)) ? 11'(MAX_MINUTES) : 11'(mins_c);
      end
      if (cmd.done) begin
         event_kind  <= kind_ff;
         event_level <= evl_ff;
         if (kind_ff == KIND_NONE) begin
            event_time    <= '0;
            minutes_until <= '0;
            alert         <= 1'b0;
         end else begin
            event_time    <= 17'(sum_ff - 20'(dayq_ff) * 20'(DAY_SECONDS));
            minutes_until <= mins_ff;
            alert <= (delta_ff != '0) && (20'(delta_ff) <= 20'(thr_ff) * 20'd60);
         end
      end
   end
endmodule
`default_nettype wire

// ===== design/tide_next_extremum_alert.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One query is taken when start is high and busy is low, and its result beat is
// shown once the look-ahead sweep and the event arithmetic are done. A pipelined
// phase, sine and level path takes one look-ahead sample per cycle; the finish, wrap
// and done states then settle the event time, minutes and alert. busy falls in the
// cycle of the beat, so a new query can be taken then, not while one is in flight.
// rsp_valid marks the beat for one cycle and cannot be held off. Registers must be
// written by the user only while no query is in flight; the block does not enforce it.
module tide_next_extremum_alert #(
   parameter int unsigned SAMPLES         = 240,
   parameter int unsigned SINE_TABLE_BITS = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [16:0]        req_time_now,
   input  wire logic signed [17:0] req_loc_offset,
   input  wire logic [10:0]        req_alert_threshold,
   output logic                    rsp_valid,
   output logic signed [13:0]      rsp_level_now,
   output logic [1:0]              rsp_event_kind,
   output logic signed [13:0]      rsp_event_level,
   output logic [16:0]             rsp_event_time,
   output logic [10:0]             rsp_minutes_until,
   output logic                    rsp_alert,
   input  wire logic               csr_write,
   input  wire logic [3:0]         csr_index,
   input  wire logic [19:0]        csr_data
);
   import tide_pkg::*;

   logic [11:0] amp_p_ff, amp_s_ff;
   logic [19:0] rate_p_ff, rate_s_ff;
   logic [8:0]  step_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic        valid_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_p_ff  <= 12'd1200;
         amp_s_ff  <= 12'd400;
         rate_p_ff <= 20'd96057;
         rate_s_ff <= 20'd99420;
         step_ff   <= 9'd180;
      end else if (csr_write) begin
         case (csr_index)
            CSR_AMP_PRIMARY:    amp_p_ff  <= csr_data[11:0];
            CSR_AMP_SECONDARY:  amp_s_ff  <= csr_data[11:0];
            CSR_RATE_PRIMARY:   rate_p_ff <= csr_data;
            CSR_RATE_SECONDARY: rate_s_ff <= csr_data;
            CSR_STEP_SECONDS:   step_ff   <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   tide_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   tide_dp #(
      .SAMPLES         (SAMPLES),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .sts             (sts),
      .amp_primary     (amp_p_ff),
      .amp_secondary   (amp_s_ff),
      .rate_primary    (rate_p_ff),
      .rate_secondary  (rate_s_ff),
      .step_seconds    (step_ff),
      .time_now        (req_time_now),
      .loc_offset      (req_loc_offset),
      .alert_threshold (req_alert_threshold),
      .out_valid       (valid_raw),
      .level_now       (rsp_level_now),
      .event_kind      (rsp_event_kind),
      .event_level     (rsp_event_level),
      .event_time      (rsp_event_time),
      .minutes_until   (rsp_minutes_until),
      .alert           (rsp_alert)
   );

   assign rsp_valid = valid_raw && !reset;

   a_no_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result beat while busy");
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_kind != 2'd3) else $error("bad event kind");
   a_none_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == KIND_NONE) |-> !rsp_alert && rsp_minutes_until == '0)
      else $error("alert without event");
endmodule
`default_nettype wire

// ===== tb/sv/tb_tide_next_extremum_alert.sv =====
`timescale 1ns / 1ps
module tb_tide_next_extremum_alert;
   import tide_pkg::*;

   localparam int unsigned SAMPLES    = 240;
   localparam int unsigned STALL_MAX  = 4000;
   localparam int unsigned DRAIN_WAIT = 800;

   typedef struct {
      logic signed [13:0] level_now;
      logic [1:0]         event_kind;
      logic signed [13:0] event_level;
      logic [16:0]        event_time;
      logic [10:0]        minutes_until;
      logic               alert;
   } tide_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [16:0]        req_time_now = '0;
   logic signed [17:0] req_loc_offset = '0;
   logic [10:0]        req_alert_threshold = '0;
   logic               rsp_valid;
   logic signed [13:0] rsp_level_now;
   logic [1:0]         rsp_event_kind;
   logic signed [13:0] rsp_event_level;
   logic [16:0]        rsp_event_time;
   logic [10:0]        rsp_minutes_until;
   logic               rsp_alert;
   logic               csr_write = 1'b0;
   logic [3:0]         csr_index = '0;
   logic [19:0]        csr_data = '0;

   logic [11:0] amp_primary;
   logic [11:0] amp_secondary;
   logic [19:0] rate_primary;
   logic [19:0] rate_secondary;
   logic [8:0]  step_seconds;

   tide_result_type tide_expected[$];
   int          error_count = 0;
   int          stall_cycles = 0;
   bit          quiet = 1'b0;

   tide_next_extremum_alert i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_time_now(req_time_now), .req_loc_offset(req_loc_offset),
      .req_alert_threshold(req_alert_threshold),
      .rsp_valid(rsp_valid), .rsp_level_now(rsp_level_now),
      .rsp_event_kind(rsp_event_kind), .rsp_event_level(rsp_event_level),
      .rsp_event_time(rsp_event_time), .rsp_minutes_until(rsp_minutes_until),
      .rsp_alert(rsp_alert),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int sine_q14(input logic [31:0] phase);
      int unsigned a, q, r, z, z2, u, s;
      a = (int'(phase >> 22) << 6) & 32'hFFFF;
      q = a >> 14;
      r = a & 32'h3FFF;
      z = q[0] ? 16384 - r : r;
      z2 = (z * z) >> 14;
      u = 10583 - ((1231 * z2) >> 14);
      u = 25736 - ((u * z2) >> 14);
      s = (u * z) >> 14;
      return (q >= 2) ? -int'(s) : int'(s);
   endfunction

   function automatic int tide_level(input longint t);
      logic [31:0] ph1, ph2;
      longint      v;
      ph1 = t[31:0] * {12'd0, rate_primary};
      ph2 = t[31:0] * {12'd0, rate_secondary};
      v = longint'(amp_primary) * sine_q14(ph1)
          + longint'(amp_secondary) * sine_q14(ph2) + 8192;
      return int'(v >>> 14);
   endfunction

   function automatic tide_result_type predict_extremum(input logic [16:0] now,
                                                        input logic signed [17:0] offset,
                                                        input logic [10:0] threshold);
      tide_result_type res;
      longint       base, delta, minutes;
      int           prev, mid, cur, high_idx, low_idx, high_val, low_val, idx;
      bit           high_ok, low_ok;
      base = longint'(now) + longint'(offset);
      prev = 0;
      mid = 0;
      high_ok = 0;
      low_ok = 0;
      high_idx = 0;
      low_idx = 0;
      high_val = 0;
      low_val = 0;
      idx = 0;
      res.level_now = 14'(tide_level(base));
      for (int i = 0; i <= SAMPLES; i++) begin
         cur = tide_level(base + longint'(i) * longint'(step_seconds));
         if (i >= 2) begin
            if (mid > prev && mid > cur) begin
               if (!high_ok) begin
                  high_ok = 1;
                  high_idx = i - 1;
                  high_val = mid;
               end
            end else if (mid < prev && mid < cur) begin
               if (!low_ok) begin
                  low_ok = 1;
                  low_idx = i - 1;
                  low_val = mid;
               end
            end
         end
         prev = mid;
         mid = cur;
      end
      res.event_kind = KIND_NONE;
      res.event_level = '0;
      res.event_time = '0;
      res.minutes_until = '0;
      res.alert = 1'b0;
      if (high_ok && (!low_ok || high_idx < low_idx)) begin
         res.event_kind = KIND_HIGH;
         idx = high_idx;
         res.event_level = 14'(high_val);
      end else if (low_ok) begin
         res.event_kind = KIND_LOW;
         idx = low_idx;
         res.event_level = 14'(low_val);
      end
      if (res.event_kind != KIND_NONE) begin
         delta = longint'(idx) * longint'(step_seconds);
         res.event_time = 17'((longint'(now) + delta) % DAY_SECONDS);
         minutes = delta / 60;
         res.minutes_until = 11'((minutes > MAX_MINUTES) ? MAX_MINUTES : minutes);
         res.alert = (delta > 0 && delta <= longint'(threshold) * 60);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      tide_result_type want;
      if (!reset && rsp_valid) begin
         if (tide_expected.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = tide_expected.pop_back();
            if (rsp_level_now !== want.level_now)
               report_mismatch("level_now", rsp_level_now, want.level_now);
            if (rsp_event_kind !== want.event_kind)
               report_mismatch("event_kind", rsp_event_kind, want.event_kind);
            if (rsp_event_level !== want.event_level)
               report_mismatch("event_level", rsp_event_level, want.event_level);
            if (rsp_event_time !== want.event_time)
               report_mismatch("event_time", rsp_event_time, want.event_time);
            if (rsp_minutes_until !== want.minutes_until)
               report_mismatch("minutes_until", rsp_minutes_until, want.minutes_until);
            if (rsp_alert !== want.alert)
               report_mismatch("alert", rsp_alert, want.alert);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [3:0] index, input logic [19:0] value);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (index)
         CSR_AMP_PRIMARY:    amp_primary = value[11:0];
         CSR_AMP_SECONDARY:  amp_secondary = value[11:0];
         CSR_RATE_PRIMARY:   rate_primary = value;
         CSR_RATE_SECONDARY: rate_secondary = value;
         CSR_STEP_SECONDS:   step_seconds = value[8:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (tide_expected.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic configure(input logic [11:0] amp1, input logic [11:0] amp2,
                            input logic [19:0] rate1, input logic [19:0] rate2,
                            input logic [8:0] step);
      drain();
      write_reg(CSR_AMP_PRIMARY, {8'd0, amp1});
      write_reg(CSR_AMP_SECONDARY, {8'd0, amp2});
      write_reg(CSR_RATE_PRIMARY, rate1);
      write_reg(CSR_RATE_SECONDARY, rate2);
      write_reg(CSR_STEP_SECONDS, {11'd0, step});
   endtask

   task automatic send_query(input logic [16:0] now, input logic signed [17:0] offset,
                             input logic [10:0] threshold);
      if (!quiet && $urandom_range(99) < 14) begin
         start = 1'b0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
      start = 1'b1;
      req_time_now = now;
      req_loc_offset = offset;
      req_alert_threshold = threshold;
      do @(posedge clock); while (busy);
      tide_expected.push_front(predict_extremum(now, offset, threshold));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic send_random();
      logic [16:0]        now;
      logic signed [17:0] offset;
      now = ($urandom_range(19) == 0) ? 17'($urandom) : 17'($urandom_range(86399));
      offset = ($urandom_range(19) == 0) ? 18'($urandom)
               : 18'(int'($urandom_range(172798)) - 86399);
      send_query(now, offset, ($urandom_range(9) == 0) ? 11'($urandom)
                              : 11'($urandom_range(1440)));
   endtask

   task automatic test_field_extremes();
      send_query(17'd0, 18'sd0, 11'd0);
      send_query(17'd86399, 18'sd0, 11'd1440);
      send_query(17'd0, -18'sd86399, 11'd1);
      send_query(17'd86399, 18'sd86399, 11'd1440);
      send_query(17'h1FFFF, 18'sh1FFFF, 11'h7FF);
      send_query(17'h1FFFF, -18'sh20000, 11'd0);
      send_query(17'd43200, -18'sd1, 11'd60);
      send_query(17'd3600, 18'sd1, 11'd3);
   endtask

   task automatic test_no_event();
      configure(12'd0, 12'd0, 20'd96057, 20'd99420, 9'd180);
      send_query(17'd1000, 18'sd500, 11'd1440);
      configure(12'd4095, 12'd4095, 20'd0, 20'd0, 9'd180);
      send_query(17'd5000, -18'sd700, 11'd1440);
      configure(12'd1200, 12'd400, 20'd96057, 20'd99420, 9'd0);
      send_query(17'd20000, 18'sd0, 11'd1440);
   endtask

   task automatic test_register_extremes();
      configure(12'd4095, 12'd4095, 20'hFFFFF, 20'hFFFFF, 9'd1);
      send_query(17'd0, 18'sd0, 11'd1);
      send_query(17'd86399, -18'sd86399, 11'd1440);
      configure(12'd4095, 12'd0, 20'd1, 20'd1, 9'd360);
      send_query(17'd12345, 18'sd4321, 11'd1440);
      configure(12'd1200, 12'd400, 20'd96057, 20'd99420, 9'h1FF);
      send_query(17'd100, 18'sd0, 11'd1440);
      send_query(17'd70000, 18'sd30000, 11'h7FF);
      configure(12'd2000, 12'd1500, 20'd48000, 20'd51000, 9'd360);
      send_query(17'd100, 18'sd0, 11'd1440);
      send_query(17'd50000, -18'sd20000, 11'd700);
   endtask

   task automatic test_random_queries();
      for (int phase_n = 0; phase_n < 6; phase_n++) begin
         if (phase_n == 0)
            configure(12'd1200, 12'd400, 20'd96057, 20'd99420, 9'd180);
         else if (phase_n == 5)
            configure(12'd4095, 12'd4095, 20'hFFFFF, 20'hFFFFF, 9'd1);
         else
            configure(12'($urandom), 12'($urandom),
                      ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(20000, 400000)),
                      ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(20000, 400000)),
                      9'($urandom_range(1, 360)));
         for (int n = 0; n < 193; n++) begin
            quiet = (phase_n == 2 && n >= 40 && n < 120);
            if (phase_n == 3 && n == 100) drain();
            send_random();
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      amp_primary = 12'd1200;
      amp_secondary = 12'd400;
      rate_primary = 20'd96057;
      rate_secondary = 20'd99420;
      step_seconds = 9'd180;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_field_extremes();
      test_no_event();
      test_register_extremes();
      test_random_queries();
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && tide_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ===== files.f =====
design/tide_pkg.sv
design/tide_ctrl.sv
design/tide_dp.sv
design/tide_next_extremum_alert.sv
tb/sv/tb_tide_next_extremum_alert.sv
